@@ rtl/core/pixel_run_length_encoder_macros.svh @@
// Assertion macros for the pixel run-length encoder checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PIXEL_RUN_LENGTH_ENCODER_MACROS_SVH
`define PIXEL_RUN_LENGTH_ENCODER_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define PRLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition in one cycle implies a signal holds its value into the next.
`define PRLE_ASSERT_HOLD(label, cond, sig, msg) \
    `PRLE_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

@@ rtl/core/prle_pkg.sv @@
// Shared types and constants of the pixel run-length encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package prle_pkg;

    localparam logic [15:0] RUN_MAX        = 16'hFFFF;
    localparam logic [24:0] RECORD_BYTES   = 25'd6;
    localparam logic [24:0] TWO_RECORDS    = 25'd12;
    localparam logic [23:0] CAPACITY_RESET = 24'hFFFFFF;

    // Configuration port: one 32-bit register at byte address 0.
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam logic        REG_CAPACITY = 1'b0;

    // Queue between the front and back parts.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [15:0] run_length;
        logic [31:0] pixel_value;
        logic        last_run;
        logic        overflow;
        logic [23:0] total_bytes;
    } t_record;

    // One queue entry holds all records caused by one pixel.
    typedef struct packed {
        t_record first;
        t_record second;
        logic    has_second;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic t_record error_record(input logic [23:0] total);
        t_record rec;
        rec.run_length  = '0;
        rec.pixel_value = '0;
        rec.last_run    = 1'b1;
        rec.overflow    = 1'b1;
        rec.total_bytes = total;
        return rec;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pixel_run_length_encoder.sv @@
// Top level of the pixel run-length encoder: configuration register, front
// part, record queue and back part. Uses prle_pkg, prle_front, prle_fifo, prle_back.
//
//   Channel   Direction  Handshake                 Beat contents
//   --------  ---------  ------------------------  --------------------------------------
//   in        input      i_in_valid / o_in_stall   i_pixel, i_last_pixel
//   out       output     o_out_valid / i_out_stall run, pixel, last, overflow, total bytes
//   config    input      APB psel/penable/pwrite   output_capacity at byte address 0
//
// One pixel is taken per cycle while the queue is not full. The front part
// decides every record of a pixel in the cycle it is accepted and pushes them as
// one queue entry, from which the back part loads the output register.
// A pixel that closes a run and also ends the image yields two records; the back
// part sends the first and then the second, and pops no queue entry in between.
// The four-entry queue absorbs such bursts and output stalls; the input stalls only
// when that queue is full. Reset is synchronous and active low; it empties the
// queue and the output register and sets the capacity to its full value.
`default_nettype none

module pixel_run_length_encoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Pixel input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [31:0]                         i_pixel,
    input  wire logic                                i_last_pixel,
    // Record output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [15:0]                              o_run_length,
    output logic [31:0]                              o_pixel_value,
    output logic                                     o_last_run,
    output logic                                     o_overflow,
    output logic [23:0]                              o_total_bytes,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [prle_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    logic [23:0]          r_capacity;
    logic                 cfg_write;
    logic                 push, pop;
    prle_pkg::t_entry     push_entry, head_entry;
    prle_pkg::t_fifo_stat fifo_stat;
    prle_pkg::t_record    out_record;

    // The register index is the word address; the low two bits select a byte
    // within the word and are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[prle_pkg::CFG_ADDR_W-1] == prle_pkg::REG_CAPACITY) ?
                       {8'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= prle_pkg::CAPACITY_RESET;
        end else if (cfg_write &&
                     paddr[prle_pkg::CFG_ADDR_W-1] == prle_pkg::REG_CAPACITY) begin
            r_capacity <= pwdata[23:0];
        end
    end

    // Front part: run tracking and the byte budget check.
    prle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capacity   (r_capacity),
        .i_valid      (i_in_valid),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .i_stat       (fifo_stat),
        .o_stall      (o_in_stall),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Queue of per-pixel record groups.
    prle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (fifo_stat)
    );

    // Back part: one record per output beat.
    prle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_stat   (fifo_stat),
        .o_pop    (pop),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_record (out_record)
    );

    assign o_run_length  = out_record.run_length;
    assign o_pixel_value = out_record.pixel_value;
    assign o_last_run    = out_record.last_run;
    assign o_overflow    = out_record.overflow;
    assign o_total_bytes = out_record.total_bytes;

endmodule

`default_nettype wire

@@ rtl/core/prle_front.sv @@
// Front part of the encoder: accepts pixels, tracks the open run and the byte
// budget, and pushes the records each pixel causes as one queue entry. Uses prle_pkg.
`default_nettype none

module prle_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [23:0]          i_capacity,
    input  wire logic                 i_valid,
    input  wire logic [31:0]          i_pixel,
    input  wire logic                 i_last_pixel,
    input  wire prle_pkg::t_fifo_stat i_stat,
    output logic                      o_stall,
    output logic                      o_push,
    output prle_pkg::t_entry          o_entry
);

    logic [31:0] r_held, n_held;
    logic [15:0] r_count, n_count;
    logic [23:0] r_bytes, n_bytes;
    logic        r_open, n_open;
    logic        r_aborted, n_aborted;

    logic        accept;
    logic [24:0] sum1, sum2;
    logic        fits1, fits2;
    logic        closes;
    logic [15:0] run_cnt;
    logic [31:0] run_px;

    assign o_stall = i_stat.full;
    assign accept  = i_valid && !i_stat.full;

    assign sum1   = {1'b0, r_bytes} + prle_pkg::RECORD_BYTES;
    assign sum2   = {1'b0, r_bytes} + prle_pkg::TWO_RECORDS;
    assign fits1  = sum1 <= {1'b0, i_capacity};
    assign fits2  = sum2 <= {1'b0, i_capacity};
    assign closes = r_open && !(i_pixel == r_held && r_count != prle_pkg::RUN_MAX);

    // Run as it stands after this pixel when the pixel does not close it.
    assign run_cnt = r_open ? r_count + 16'd1 : 16'd1;
    assign run_px  = r_open ? r_held : i_pixel;

    always_comb begin
        n_held    = r_held;
        n_count   = r_count;
        n_bytes   = r_bytes;
        n_open    = r_open;
        n_aborted = r_aborted;
        o_push    = 1'b0;
        o_entry   = '0;

        if (accept) begin
            if (r_aborted) begin
                // Remaining pixels of an aborted image are dropped.
                if (i_last_pixel) begin
                    n_aborted = 1'b0;
                end
            end else if (closes) begin
                o_push = 1'b1;
                if (fits1) begin
                    o_entry.first = prle_pkg::t_record'{run_length: r_count,
                                      pixel_value: r_held,
                                      last_run: 1'b0, overflow: 1'b0,
                                      total_bytes: sum1[23:0]};
                    n_held  = i_pixel;
                    n_count = 16'd1;
                    n_bytes = sum1[23:0];
                    if (i_last_pixel) begin
                        // The fresh one-pixel run is closed at once as well.
                        o_entry.has_second = 1'b1;
                        o_entry.second = fits2 ?
                            prle_pkg::t_record'{run_length: 16'd1, pixel_value: i_pixel,
                              last_run: 1'b1, overflow: 1'b0,
                              total_bytes: sum2[23:0]} :
                            prle_pkg::error_record(sum1[23:0]);
                        n_held  = '0;
                        n_count = '0;
                        n_bytes = '0;
                        n_open  = 1'b0;
                    end
                end else begin
                    o_entry.first = prle_pkg::error_record(r_bytes);
                    n_held    = '0;
                    n_count   = '0;
                    n_bytes   = '0;
                    n_open    = 1'b0;
                    n_aborted = !i_last_pixel;
                end
            end else begin
                n_held  = run_px;
                n_count = run_cnt;
                n_open  = 1'b1;
                if (i_last_pixel) begin
                    o_push = 1'b1;
                    o_entry.first = fits1 ?
                        prle_pkg::t_record'{run_length: run_cnt, pixel_value: run_px,
                          last_run: 1'b1, overflow: 1'b0,
                          total_bytes: sum1[23:0]} :
                        prle_pkg::error_record(r_bytes);
                    n_held  = '0;
                    n_count = '0;
                    n_bytes = '0;
                    n_open  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_count   <= '0;
            r_bytes   <= '0;
            r_open    <= 1'b0;
            r_aborted <= 1'b0;
        end else begin
            r_held    <= n_held;
            r_count   <= n_count;
            r_bytes   <= n_bytes;
            r_open    <= n_open;
            r_aborted <= n_aborted;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/prle_fifo.sv @@
// Short queue of record entries between the front and back parts.
// Uses prle_pkg for the entry type and depth.
`default_nettype none

module prle_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire prle_pkg::t_entry     i_entry,
    input  wire logic                 i_pop,
    output prle_pkg::t_entry          o_entry,
    output prle_pkg::t_fifo_stat      o_stat
);

    prle_pkg::t_entry                r_mem [prle_pkg::FIFO_DEPTH];
    logic [prle_pkg::FIFO_AW-1:0]    r_wr, r_rd;
    logic [prle_pkg::FIFO_AW:0]      r_count;
    logic                            do_push, do_pop;

    assign o_stat.full  = r_count == (prle_pkg::FIFO_AW + 1)'(prle_pkg::FIFO_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/prle_back.sv @@
// Back part of the encoder: unpacks queue entries into single records and
// drives the output register. Uses prle_pkg.
`default_nettype none

module prle_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire prle_pkg::t_entry     i_entry,
    input  wire prle_pkg::t_fifo_stat i_stat,
    output logic                      o_pop,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output prle_pkg::t_record         o_record
);

    prle_pkg::t_record r_out, r_pend;
    logic              r_out_valid, r_pend_valid;
    logic              load;

    // The output register can take a new record when empty or being drained.
    assign load     = !r_out_valid || !i_stall;
    assign o_pop    = load && !r_pend_valid && !i_stat.empty;
    assign o_valid  = r_out_valid;
    assign o_record = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (load) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= !i_stat.empty;
                r_pend_valid <= !i_stat.empty && i_entry.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (!i_stat.empty) begin
                r_out  <= i_entry.first;
                r_pend <= i_entry.second;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/prle_checker.sv @@
// Port-level checker for the pixel run-length encoder, bound to the top level.
// Uses pixel_run_length_encoder_macros.svh.
`default_nettype none

`include "pixel_run_length_encoder_macros.svh"

module prle_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_run_length,
    input wire logic [31:0] o_pixel_value,
    input wire logic        o_last_run,
    input wire logic        o_overflow,
    input wire logic [23:0] o_total_bytes
);

    logic out_held;
    logic err_beat;
    logic err_empty;
    logic run_beat;

    assign out_held  = o_out_valid && i_out_stall;
    assign err_beat  = o_out_valid && o_overflow;
    assign err_empty = (o_run_length == 16'd0) && (o_pixel_value == 32'd0);
    assign run_beat  = o_out_valid && !o_overflow;

    // A stalled output beat keeps its total byte count.
    `PRLE_ASSERT_HOLD(a_out_hold, out_held, o_total_bytes, "stalled beat changed")

    // An error record always ends the image.
    `PRLE_ASSERT(a_ovf_last, err_beat |-> o_last_run, "error record not last")

    // An error record carries no run.
    `PRLE_ASSERT(a_ovf_zero, err_beat |-> err_empty, "error record not zero")

    // A normal record always covers at least one pixel.
    `PRLE_ASSERT(a_run_nonzero, run_beat |-> o_run_length != 16'd0, "empty run emitted")

endmodule

bind pixel_run_length_encoder prle_checker u_prle_checker (.*);

`default_nettype wire

@@ bench/prle_checker.sv @@
// Scoreboard for the pixel run-length encoder: watches the pixel, record and
// configuration ports, predicts every record and compares it. Uses prle_pkg.
`timescale 1ns / 1ps

module prle_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [31:0]                       pixel,
    input  logic                              last_pixel,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [15:0]                       run_length,
    input  logic [31:0]                       pixel_value,
    input  logic                              last_run,
    input  logic                              overflow,
    input  logic [23:0]                       total_bytes,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [prle_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                records_pending,
    output int                                records_seen
);

    localparam logic [prle_pkg::CFG_ADDR_W-1:0] CAP_ADDR = {prle_pkg::REG_CAPACITY, 2'b00};

    logic [31:0] held_pixel_q;
    logic [15:0] run_len_q;
    logic [23:0] bytes_q;
    logic        run_open_q;
    logic        aborted_q;
    logic [23:0] capacity_q;
    prle_pkg::t_record expected_records[$];
    int          fail_total;
    int          seen_total;

    task automatic clear_image();
        held_pixel_q = '0;
        run_len_q    = '0;
        bytes_q      = '0;
        run_open_q   = 1'b0;
        aborted_q    = 1'b0;
    endtask

    // Closes the held run into a record, or an error record if it does not fit.
    task automatic close_run(input bit is_last, output bit fit);
        prle_pkg::t_record rec;
        if ({1'b0, bytes_q} + prle_pkg::RECORD_BYTES > {1'b0, capacity_q}) begin
            rec.run_length  = '0;
            rec.pixel_value = '0;
            rec.last_run    = 1'b1;
            rec.overflow    = 1'b1;
            rec.total_bytes = bytes_q;
            fit = 1'b0;
        end else begin
            bytes_q         = bytes_q + prle_pkg::RECORD_BYTES[23:0];
            rec.run_length  = run_len_q;
            rec.pixel_value = held_pixel_q;
            rec.last_run    = is_last;
            rec.overflow    = 1'b0;
            rec.total_bytes = bytes_q;
            fit = 1'b1;
        end
        expected_records.push_back(rec);
    endtask

    task automatic encode_pixel(input logic [31:0] px, input bit is_last);
        bit fit;
        fit = 1'b1;
        if (aborted_q) begin
            if (is_last) clear_image();
        end else begin
            if (!run_open_q) begin
                held_pixel_q = px;
                run_len_q    = 16'd1;
                run_open_q   = 1'b1;
            end else if (px == held_pixel_q && run_len_q < prle_pkg::RUN_MAX) begin
                run_len_q = run_len_q + 16'd1;
            end else begin
                close_run(1'b0, fit);
                if (fit) begin
                    held_pixel_q = px;
                    run_len_q    = 16'd1;
                end else if (is_last) begin
                    clear_image();
                end else begin
                    aborted_q = 1'b1;
                end
            end
            if (fit && is_last) begin
                close_run(1'b1, fit);
                clear_image();
            end
        end
    endtask

    task automatic report(input string what, input prle_pkg::t_record exp_rec);
        fail_total++;
        if (fail_total <= 10) begin
            $write("%0t: %s: expected run %0d px %h last %b ovf %b bytes %0d, ",
                   $realtime, what, exp_rec.run_length, exp_rec.pixel_value,
                   exp_rec.last_run, exp_rec.overflow, exp_rec.total_bytes);
            $display("got run %0d px %h last %b ovf %b bytes %0d",
                     run_length, pixel_value, last_run, overflow, total_bytes);
        end
    endtask

    initial begin
        fail_total = 0;
        seen_total = 0;
        mismatches = 0;
        records_pending = 0;
        records_seen = 0;
    end

    always @(posedge i_clk) begin
        prle_pkg::t_record exp_rec;
        if (!i_rst_n) begin
            clear_image();
            capacity_q = prle_pkg::CAPACITY_RESET;
            expected_records.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
                capacity_q = pwdata[23:0];

            if (in_valid && !in_stall)
                encode_pixel(pixel, last_pixel);

            if (out_valid && !out_stall) begin
                seen_total++;
                if (expected_records.size() == 0) begin
                    exp_rec = '0;
                    report("record with nothing expected", exp_rec);
                end else begin
                    exp_rec = expected_records.pop_front();
                    if (run_length !== exp_rec.run_length ||
                        pixel_value !== exp_rec.pixel_value ||
                        last_run !== exp_rec.last_run ||
                        overflow !== exp_rec.overflow ||
                        total_bytes !== exp_rec.total_bytes)
                        report("record mismatch", exp_rec);
                end
            end
        end
        mismatches      <= fail_total;
        records_pending <= expected_records.size();
        records_seen    <= seen_total;
    end

endmodule

@@ bench/tb_pixel_run_length_encoder.sv @@
// Testbench top of the pixel run-length encoder: clock, reset, pixel and
// configuration stimulus, output stalls and the verdict. Uses prle_pkg, prle_scoreboard.
`timescale 1ns / 1ps

module tb_pixel_run_length_encoder;

    localparam logic [prle_pkg::CFG_ADDR_W-1:0] CAP_ADDR = {prle_pkg::REG_CAPACITY, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_pixel;
    logic        i_last_pixel;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_run_length;
    logic [31:0] o_pixel_value;
    logic        o_last_run;
    logic        o_overflow;
    logic [23:0] o_total_bytes;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [prle_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int records_pending;
    int records_seen;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct;
    int stall_pct;

    // Run statistics for the closing summary.
    int pixels_sent;
    int images_sent;
    int capacity_writes;

    pixel_run_length_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_run_length  (o_run_length),
        .o_pixel_value (o_pixel_value),
        .o_last_run    (o_last_run),
        .o_overflow    (o_overflow),
        .o_total_bytes (o_total_bytes),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    prle_scoreboard u_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_valid        (i_in_valid),
        .in_stall        (o_in_stall),
        .pixel           (i_pixel),
        .last_pixel      (i_last_pixel),
        .out_valid       (o_out_valid),
        .out_stall       (i_out_stall),
        .run_length      (o_run_length),
        .pixel_value     (o_pixel_value),
        .last_run        (o_last_run),
        .overflow        (o_overflow),
        .total_bytes     (o_total_bytes),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .records_pending (records_pending),
        .records_seen    (records_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Sends one pixel beat. The sender may idle first; then the beat is held
    // until it is taken. Valid is left high so back-to-back beats need no gap.
    task automatic send_pixel(input logic [31:0] px, input bit is_last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel      <= px;
        i_last_pixel <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        pixels_sent++;
        if (is_last) images_sent++;
    endtask

    // Stops the pixel stream and waits until every predicted record has come
    // out, then waits on so no pixel is still in flight. The checker registers
    // its count, so the loop waits for an edge before it reads the count.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (records_pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // A register write: setup cycle, then access cycle until pready.
    task automatic write_capacity(input logic [23:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {8'h00, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_writes++;
    endtask

    // One image of random length. Pixels are drawn mostly from a small palette
    // and repeat often, so runs, value changes and two-record endings all
    // appear; a few pixels are fully random.
    task automatic send_image();
        int len;
        int i;
        int pick;
        logic [31:0] palette [3];
        logic [31:0] px;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        palette[0] = $urandom();
        palette[1] = palette[0] ^ (32'd1 << $urandom_range(31));
        palette[2] = $urandom();
        px = palette[2'($urandom_range(2))];
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick >= 50 && pick < 90)
                px = palette[2'($urandom_range(2))];
            else if (pick >= 90)
                px = $urandom();
            send_pixel(px, i == len - 1);
        end
    endtask

    initial begin
        int p;
        int phase_start;
        logic [23:0] capacity;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_pixel      = '0;
        i_last_pixel = 1'b0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        pixels_sent  = 0;
        images_sent  = 0;
        capacity_writes = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with no idling on either side.
        write_capacity(prle_pkg::CAPACITY_RESET);
        // A one-pixel image with all bits set.
        send_pixel(32'hFFFF_FFFF, 1'b1);
        // A run of four zeros closed by the image end.
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        // A value change on the last pixel gives two records in one beat.
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h9ABC_DEF0, 1'b1);
        send_pixel(32'h5555_5555, 1'b0);
        send_pixel(32'hAAAA_AAAA, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        drain();

        // Room for two records: the third overflows mid-image, and the rest
        // of the image, its last pixel included, is dropped.
        write_capacity(24'd12);
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'h0000_0002, 1'b0);
        send_pixel(32'h0000_0003, 1'b0);
        send_pixel(32'h0000_0004, 1'b0);
        send_pixel(32'h0000_0005, 1'b0);
        send_pixel(32'h0000_0006, 1'b1);
        drain();

        // Room for one record: the closing record of the last pixel overflows.
        write_capacity(24'd6);
        send_pixel(32'h0000_0007, 1'b0);
        send_pixel(32'h0000_0008, 1'b1);
        drain();

        // No room at all: a lone last pixel and an image whose first record
        // fails while the last pixel is handled.
        write_capacity(24'd0);
        send_pixel(32'h0000_0009, 1'b1);
        send_pixel(32'h0000_000A, 1'b0);
        send_pixel(32'h0000_000B, 1'b1);
        drain();

        // Random part: eight phases, each with its own capacity and idling.
        for (p = 0; p < 8; p++) begin
            case (p)
                0: capacity = prle_pkg::CAPACITY_RESET;
                1: capacity = 24'd36;
                2: capacity = 24'd0;
                3: capacity = 24'(6 * $urandom_range(1, 10));
                4: capacity = 24'($urandom_range(0, 100));
                5: capacity = 24'd7;
                6: capacity = 24'd60;
                default: capacity = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            write_capacity(capacity);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < 150) send_image();
            // Every phase ends with the sender paused until all records are in.
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d pixels in %0d images under %0d capacity settings;",
                 pixels_sent, images_sent, capacity_writes);
        $display("checked %0d records, including two-record endings and overflow aborts.",
                 records_seen);
        if (mismatches == 0 && records_pending == 0) begin
            $display("tb_pixel_run_length_encoder: PASS");
        end else begin
            if (records_pending != 0)
                $display("%0d expected records never arrived", records_pending);
            $display("tb_pixel_run_length_encoder: FAIL");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d records still expected", records_pending);
        $display("tb_pixel_run_length_encoder: FAIL");
        $finish;
    end

endmodule
